// ===== hdl/stdt_pkg.sv =====
// ----------------------------------------------------------------------------
// stdt_pkg
// Shared types, constants and helpers for the source time dependency tracker.
// ----------------------------------------------------------------------------
package stdt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int TIME_BITS     = 48;
    localparam int ID_BITS       = 32;
    localparam int STATUS_BITS   = 3;
    localparam int COUNT_BITS    = 7;
    localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] CMD_UPDATE  = 2'd0;
    localparam logic [1:0] CMD_WAIT    = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    localparam logic [STATUS_BITS-1:0] STS_DONE    = 3'd0;
    localparam logic [STATUS_BITS-1:0] STS_PROCEED = 3'd1;
    localparam logic [STATUS_BITS-1:0] STS_WAIT    = 3'd2;
    localparam logic [STATUS_BITS-1:0] STS_WOKEN   = 3'd3;
    localparam logic [STATUS_BITS-1:0] STS_UNKNOWN = 3'd4;
    localparam logic [STATUS_BITS-1:0] STS_FULL    = 3'd5;

    // Command fields held steady and seen by every cell during one pass.
    typedef struct packed {
        logic [1:0]           cmd;
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] tv;
        logic                 init;
        logic                 found;
    } t_bc;

    // Token that walks down the row, one cell per cycle.
    typedef struct packed {
        logic                 vld;
        logic                 apply;
        logic                 found;
        logic                 claimed;
        logic                 min_any;
        logic [TIME_BITS-1:0] min_time;
        logic [CNT_BITS-1:0]  count;
    } t_carry;

    // Saturating unsigned add of two times.
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    endfunction

endpackage

// ===== hdl/stdt_cell.sv =====
// ----------------------------------------------------------------------------
// stdt_cell
// One table entry. Updates itself when the token passes and hands the token,
// with its running minimum and count, on to the next cell.
// ----------------------------------------------------------------------------
module stdt_cell
    import stdt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_bc    i_bc,
    input  t_carry i_carry,
    output t_carry o_carry
);

    logic                 r_valid;
    logic [ID_BITS-1:0]   r_source;
    logic [TIME_BITS-1:0] r_time;
    t_carry               r_carry;

    logic                 n_valid;
    logic [ID_BITS-1:0]   n_source;
    logic [TIME_BITS-1:0] n_time;
    t_carry               n_carry;
    logic                 hit;
    logic                 claim;

    always_comb begin
        hit      = r_valid && (r_source == i_bc.id);
        claim    = 1'b0;
        n_valid  = r_valid;
        n_source = r_source;
        n_time   = r_time;
        if (i_carry.vld && i_carry.apply) begin
            unique case (i_bc.cmd)
                CMD_UPDATE: begin
                    if (hit) begin
                        if (i_bc.tv > r_time) begin
                            n_time = i_bc.tv;
                        end
                    end else if (!r_valid && i_bc.init && !i_bc.found
                                 && !i_carry.claimed) begin
                        // First free entry takes the new source.
                        claim    = 1'b1;
                        n_valid  = 1'b1;
                        n_source = i_bc.id;
                        n_time   = i_bc.tv;
                    end
                end
                CMD_ADVANCE: begin
                    if (r_valid) begin
                        n_time = sat_add(r_time, i_bc.tv);
                    end
                end
                default: begin
                end
            endcase
        end

        n_carry         = i_carry;
        n_carry.found   = i_carry.found | hit;
        n_carry.claimed = i_carry.claimed | claim;
        if (i_carry.apply && n_valid) begin
            n_carry.count = i_carry.count + CNT_BITS'(1);
            if (!i_carry.min_any || (n_time < i_carry.min_time)) begin
                n_carry.min_any  = 1'b1;
                n_carry.min_time = n_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_source         <= n_source;
        r_time           <= n_time;
        r_carry.apply    <= n_carry.apply;
        r_carry.found    <= n_carry.found;
        r_carry.claimed  <= n_carry.claimed;
        r_carry.min_any  <= n_carry.min_any;
        r_carry.min_time <= n_carry.min_time;
        r_carry.count    <= n_carry.count;
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_carry.vld <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_carry.vld <= n_carry.vld;
        end
    end

    assign o_carry = r_carry;

endmodule

// ===== hdl/source_time_dependency_tracker.sv =====
// ----------------------------------------------------------------------------
// source_time_dependency_tracker
// Table of sources and the times up to which each allows progress, held in a
// row of cells that a token walks through, with a small sequencer on top.
// ----------------------------------------------------------------------------
// An update runs a scan pass and then an apply pass down the row; every other
// item runs only the apply pass. The result is registered, then moved to the
// output register. One item at a time: the next item is taken only once the
// result has moved to the output register, later while an earlier result
// still waits there. The token walking one cell per cycle sets the pace.
// Reset (synchronous, active low) empties the table and clears the waiter;
// there is no clearing pass, the block is ready in the first cycle after.
// ----------------------------------------------------------------------------
module source_time_dependency_tracker
    import stdt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: source_id [31:0], time_value [79:32], step_length [127:80]
    input  logic [127:0] i_s_tdata,
    // tuser: cmd [1:0], init_phase [2]
    input  logic [2:0]   i_s_tuser,
    // Result stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: min_time [47:0], entry_count [54:48], zero [55]
    output logic [55:0]  o_m_tdata,
    // tuser: status [2:0]
    output logic [2:0]   o_m_tuser
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]             r_state, n_state;
    t_bc                    r_bc, n_bc;
    logic [TIME_BITS-1:0]   r_req_target, n_req_target;
    t_carry                 r_inj, n_inj;
    logic                   r_waiter_pending, n_waiter_pending;
    logic [TIME_BITS-1:0]   r_waiter_target, n_waiter_target;
    logic [STATUS_BITS-1:0] r_res_status, n_res_status;
    logic [TIME_BITS-1:0]   r_res_min, n_res_min;
    logic [COUNT_BITS-1:0]  r_res_count, n_res_count;
    logic                   r_out_vld, n_out_vld;
    logic [55:0]            r_out_data, n_out_data;
    logic [2:0]             r_out_user, n_out_user;

    // Token path: element 0 is fed by the sequencer, the last one returns.
    t_carry                 c_chain [TABLE_ENTRIES+1];
    t_carry                 c_end;
    logic                   s_accept;
    logic [TIME_BITS-1:0]   s_min;

    assign c_chain[0] = r_inj;
    assign c_end      = c_chain[TABLE_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            stdt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_bc    (r_bc),
                .i_carry (c_chain[g]),
                .o_carry (c_chain[g+1])
            );
        end
    endgenerate

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    // The minimum reads as zero when the table is empty.
    assign s_min      = c_end.min_any ? c_end.min_time : '0;

    always_comb begin
        n_state          = r_state;
        n_bc             = r_bc;
        n_req_target     = r_req_target;
        n_inj            = r_inj;
        n_inj.vld        = 1'b0;
        n_waiter_pending = r_waiter_pending;
        n_waiter_target  = r_waiter_target;
        n_res_status     = r_res_status;
        n_res_min        = r_res_min;
        n_res_count      = r_res_count;
        n_out_vld        = r_out_vld && !i_m_tready;
        n_out_data       = r_out_data;
        n_out_user       = r_out_user;

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_bc.cmd     = i_s_tuser[1:0];
                    n_bc.init    = i_s_tuser[2];
                    n_bc.id      = i_s_tdata[31:0];
                    n_bc.tv      = i_s_tdata[79:32];
                    n_bc.found   = 1'b0;
                    n_req_target = sat_add(i_s_tdata[79:32], i_s_tdata[127:80]);
                    // Updates first look for the source in a scan pass; every
                    // other command goes straight to the apply pass.
                    n_inj        = '0;
                    n_inj.vld    = 1'b1;
                    n_inj.apply  = (i_s_tuser[1:0] != CMD_UPDATE);
                    n_state      = (i_s_tuser[1:0] == CMD_UPDATE) ? ST_SCAN : ST_APPLY;
                end
            end
            ST_SCAN: begin
                if (c_end.vld) begin
                    n_bc.found  = c_end.found;
                    n_inj       = '0;
                    n_inj.vld   = 1'b1;
                    n_inj.apply = 1'b1;
                    n_state     = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (c_end.vld) begin
                    n_res_status = STS_DONE;
                    n_res_min    = s_min;
                    n_res_count  = COUNT_BITS'(c_end.count);
                    unique case (r_bc.cmd)
                        CMD_UPDATE: begin
                            if (r_bc.init) begin
                                if (!r_bc.found && !c_end.claimed) begin
                                    n_res_status = STS_FULL;
                                end
                            end else if (!r_bc.found) begin
                                n_res_status = STS_UNKNOWN;
                            end else if (r_waiter_pending && (s_min >= r_waiter_target)) begin
                                n_waiter_pending = 1'b0;
                                n_waiter_target  = '0;
                                n_res_status     = STS_WOKEN;
                            end
                        end
                        CMD_WAIT: begin
                            if (!c_end.min_any || (s_min >= r_req_target)) begin
                                n_res_status = STS_PROCEED;
                            end else begin
                                n_waiter_pending = 1'b1;
                                n_waiter_target  = r_req_target;
                                n_res_status     = STS_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold the result until the output register is free.
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {1'b0, r_res_count, r_res_min};
                    n_out_user = r_res_status;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bc             <= n_bc;
        r_req_target     <= n_req_target;
        r_inj.apply      <= n_inj.apply;
        r_inj.found      <= n_inj.found;
        r_inj.claimed    <= n_inj.claimed;
        r_inj.min_any    <= n_inj.min_any;
        r_inj.min_time   <= n_inj.min_time;
        r_inj.count      <= n_inj.count;
        r_res_status     <= n_res_status;
        r_res_min        <= n_res_min;
        r_res_count      <= n_res_count;
        r_out_data       <= n_out_data;
        r_out_user       <= n_out_user;
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_inj.vld        <= 1'b0;
            r_waiter_pending <= 1'b0;
            r_waiter_target  <= '0;
            r_out_vld        <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_inj.vld        <= n_inj.vld;
            r_waiter_pending <= n_waiter_pending;
            r_waiter_target  <= n_waiter_target;
            r_out_vld        <= n_out_vld;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // A token only returns from the row while an item is being worked on.
    a_token_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_end.vld |-> (r_state == ST_SCAN || r_state == ST_APPLY))
        else $error("token returned while no item was in work");

    // A token is launched only when a scan or apply pass begins.
    a_inject_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inj.vld |-> (r_state == ST_SCAN || r_state == ST_APPLY))
        else $error("token launched outside a pass");

    // The count reported never exceeds the size of the table.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[54:48] <= COUNT_BITS'(TABLE_ENTRIES)))
        else $error("entry count beyond table size");

    // A woken waiter leaves the waiter cleared behind it.
    a_woken_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY && c_end.vld && n_res_status == STS_WOKEN)
        |=> !r_waiter_pending)
        else $error("waiter still pending after wake");

endmodule

// ===== verif/tb_source_time_dependency_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_source_time_dependency_tracker
// Self-checking bench for the source time dependency tracker: a directed
// opening, then random update, wait, advance and unused-code traffic, checked item by item
// against an in-bench model of the source table and the pending waiter.
// ----------------------------------------------------------------------------
module tb_source_time_dependency_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    import stdt_pkg::*;

    typedef logic [TIME_BITS-1:0] t_tstamp;

    // One input item as the bench sees it.
    typedef struct packed {
        logic [1:0]         cmd;
        logic [ID_BITS-1:0] id;
        t_tstamp            tv;
        t_tstamp            step;
        logic               init;
    } t_notice;

    // One result item.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        t_tstamp                min_time;
        logic [COUNT_BITS-1:0]  count;
    } t_outcome;

    // The fourth command code is not used by the block and must be ignored.
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam t_tstamp    TIME_MAX      = {TIME_BITS{1'b1}};
    localparam int         RANDOM_ITEMS  = 400;
    localparam int         LIMIT_CYCLES  = 1_000_000;
    localparam int         HOLD_CYCLES   = 500;
    // Longest time from acceptance to result, plus some margin for the tail.
    localparam int         DRAIN_CYCLES  = 2 * TABLE_ENTRIES + 3 + 50;
    // The table is modelled twice: once while the stimulus is planned, so
    // that well-formed sequences can be built, and once as items are accepted.
    localparam int         PLAN_BANK     = 0;
    localparam int         CHECK_BANK    = 1;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // tdata: source_id [31:0], time_value [79:32], step_length [127:80]
    logic [127:0]          i_s_tdata  = '0;
    // tuser: cmd [1:0], init_phase [2]
    logic [2:0]            i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // tdata: min_time [47:0], entry_count [54:48], zero [55]
    logic [55:0]           o_m_tdata;
    // tuser: status [2:0]
    logic [2:0]            o_m_tuser;

    // Model of the source table, one copy per bank.
    bit                    tbl_valid [2][TABLE_ENTRIES];
    logic [ID_BITS-1:0]    tbl_src   [2][TABLE_ENTRIES];
    t_tstamp               tbl_time  [2][TABLE_ENTRIES];
    bit                    wt_pending [2];
    t_tstamp               wt_target  [2];

    t_notice               item_q[$];     // items still to be offered
    t_outcome              result_q[$];   // results owed by the block
    int                    n_directed  = 0;
    int                    n_accepted  = 0;
    int                    n_errors    = 0;
    int                    n_cycles    = 0;
    int                    hold_left   = 0;
    bit                    hold_done   = 1'b0;
    int                    status_seen [8];

    source_time_dependency_tracker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    // Every time sum clips at the top of the range.
    function automatic t_tstamp sat_time(input t_tstamp a, input t_tstamp b);
        if (b > TIME_MAX - a)
            return TIME_MAX;
        return a + b;
    endfunction

    // Lowest stored time, or zero when the table is empty.
    function automatic t_tstamp table_floor(input int b);
        t_tstamp m;
        bit      any;
        m   = '0;
        any = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[b][i] && (!any || tbl_time[b][i] < m)) begin
                m   = tbl_time[b][i];
                any = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic int live_count(input int b);
        int n;
        n = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[b][i])
                n++;
        return n;
    endfunction

    function automatic int source_slot(input int b, input logic [ID_BITS-1:0] id);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[b][i] && tbl_src[b][i] == id)
                return i;
        return -1;
    endfunction

    function automatic int free_slot(input int b);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!tbl_valid[b][i])
                return i;
        return -1;
    endfunction

    // Applies one item to a bank and returns the result it should produce.
    function automatic t_outcome tracker_step(input int b, input t_notice n);
        int                     k;
        int                     f;
        logic [STATUS_BITS-1:0] st;
        t_tstamp                target;
        t_outcome               o;
        st = STS_DONE;
        k  = source_slot(b, n.id);
        case (n.cmd)
            CMD_UPDATE: begin
                if (n.init) begin
                    // Initialisation keeps the larger time and never wakes anyone.
                    if (k >= 0) begin
                        if (n.tv > tbl_time[b][k])
                            tbl_time[b][k] = n.tv;
                    end else begin
                        f = free_slot(b);
                        if (f < 0) begin
                            st = STS_FULL;
                        end else begin
                            tbl_valid[b][f] = 1'b1;
                            tbl_src[b][f]   = n.id;
                            tbl_time[b][f]  = n.tv;
                        end
                    end
                end else if (k < 0) begin
                    st = STS_UNKNOWN;
                end else begin
                    if (tbl_time[b][k] < n.tv)
                        tbl_time[b][k] = n.tv;
                    // The waiter check runs even when the time was not raised.
                    if (wt_pending[b] && table_floor(b) >= wt_target[b]) begin
                        wt_pending[b] = 1'b0;
                        wt_target[b]  = '0;
                        st            = STS_WOKEN;
                    end
                end
            end
            CMD_WAIT: begin
                target = sat_time(n.tv, n.step);
                if (live_count(b) == 0 || table_floor(b) >= target) begin
                    st = STS_PROCEED;
                end else begin
                    wt_pending[b] = 1'b1;
                    wt_target[b]  = target;
                    st            = STS_WAIT;
                end
            end
            CMD_ADVANCE: begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (tbl_valid[b][i])
                        tbl_time[b][i] = sat_time(tbl_time[b][i], n.tv);
            end
            default: begin
            end
        endcase
        o.status   = st;
        o.min_time = table_floor(b);
        o.count    = COUNT_BITS'(live_count(b));
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_tstamp rand_time();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Index of a random live entry, or -1 if the table is empty.
    function automatic int pick_entry(input int b);
        int n;
        int r;
        n = live_count(b);
        if (n == 0)
            return -1;
        r = $urandom_range(0, n - 1);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[b][i]) begin
                if (r == 0)
                    return i;
                r--;
            end
        end
        return -1;
    endfunction

    task automatic queue_item(input logic [1:0] cmd, input logic [ID_BITS-1:0] id,
                              input t_tstamp tv, input t_tstamp step, input logic init);
        t_notice n;
        n.cmd  = cmd;
        n.id   = id;
        n.tv   = tv;
        n.step = step;
        n.init = init;
        item_q = {item_q, n};
        void'(tracker_step(PLAN_BANK, n));
    endtask

    // Idling phases in blocks of a hundred items after the directed opening:
    // none, sender idle, receiver stalling, both lightly.
    function automatic int idle_pct(input int n, input bit receiver);
        int ph;
        if (n < n_directed)
            return 0;
        ph = ((n - n_directed) / 100) % 4;
        case (ph)
            1:       return receiver ? 0 : 69;
            2:       return receiver ? 69 : 0;
            3:       return 7;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers the queued items in order and predicts each result
    // at the moment its item is accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : feeder
        int       pct;
        t_outcome pred;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            pct = idle_pct(n_accepted, 1'b0);
            if (i_s_tvalid && o_s_tready) begin
                pred     = tracker_step(CHECK_BANK, item_q[0]);
                result_q = {result_q, pred};
                void'(item_q.pop_front());
                n_accepted <= n_accepted + 1;
            end
            // An offered item stays on the bus until it has been taken.
            if (!i_s_tvalid || o_s_tready) begin
                if (item_q.size() > 0 && !(pct > 0 && $urandom_range(0, 99) < pct)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {item_q[0].step, item_q[0].tv, item_q[0].id};
                    i_s_tuser  <= {item_q[0].init, item_q[0].cmd};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, started once early in the random part, so
    // that the block backs up and refuses further input items.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_accepted >= n_directed + 30) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks every result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drain
        t_outcome want;
        int       pct;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                status_seen[o_m_tuser]++;
                if (result_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: expected no result, actual status %0d min %0d count %0d",
                             $realtime, o_m_tuser, o_m_tdata[47:0], o_m_tdata[54:48]);
                end else begin
                    want = result_q.pop_front();
                    if (o_m_tuser !== want.status) begin
                        n_errors++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $realtime, want.status, o_m_tuser);
                    end
                    if (o_m_tdata[47:0] !== want.min_time) begin
                        n_errors++;
                        $display("%0t: min_time mismatch, expected %0d, actual %0d",
                                 $realtime, want.min_time, o_m_tdata[47:0]);
                    end
                    if (o_m_tdata[54:48] !== want.count) begin
                        n_errors++;
                        $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                                 $realtime, want.count, o_m_tdata[54:48]);
                    end
                end
            end
            pct = idle_pct(n_accepted, 1'b1);
            i_m_tready <= (hold_left == 0) && !(pct > 0 && $urandom_range(0, 99) < pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d items accepted", n_cycles, n_accepted);
            $display("tb_source_time_dependency_tracker: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run.
    // ------------------------------------------------------------------
    initial begin : sequencer
        int      pick;
        int      slot;
        bit      broken;
        t_tstamp lo;
        t_tstamp tv;
        t_tstamp cur;
        t_tstamp back;
        t_tstamp target;

        // Directed opening. Wait on an empty table proceeds; a run-time update
        // from a source never seen is refused; the unused code does nothing;
        // an advance on an empty table changes nothing.
        queue_item(CMD_WAIT,    32'd0,          48'd5,    48'd7,    1'b0);
        queue_item(CMD_UPDATE,  32'd0,          48'd100,  48'd0,    1'b0);
        queue_item(CMD_UNUSED,  32'hFFFF_FFFF,  TIME_MAX, TIME_MAX, 1'b1);
        queue_item(CMD_ADVANCE, 32'd0,          TIME_MAX, 48'd0,    1'b0);
        // Inserts at the extreme ids and times, then keep-the-maximum checks.
        queue_item(CMD_UPDATE,  32'd0,          48'd1000, 48'd0,    1'b1);
        queue_item(CMD_UPDATE,  32'hFFFF_FFFF,  TIME_MAX, TIME_MAX, 1'b1);
        queue_item(CMD_UPDATE,  32'd0,          48'd500,  48'd0,    1'b1);
        queue_item(CMD_UPDATE,  32'd0,          48'd2000, 48'd0,    1'b1);
        // A wait that is already satisfied, then one whose target clips at the
        // top, then a second one that replaces the first target.
        queue_item(CMD_WAIT,    32'd0,          48'd1000, 48'd500,  1'b0);
        queue_item(CMD_WAIT,    32'd0,          TIME_MAX, TIME_MAX, 1'b0);
        queue_item(CMD_WAIT,    32'd0,          48'd2000, 48'd1000, 1'b0);
        // A wait that proceeds leaves the pending target alone.
        queue_item(CMD_WAIT,    32'hFFFF_FFFF,  48'd0,    48'd0,    1'b1);
        // Raise below the target: no wake.
        queue_item(CMD_UPDATE,  32'd0,          48'd2500, 48'd0,    1'b0);
        // Advance lifts the minimum past the target without waking, and
        // clips the entry already at the top.
        queue_item(CMD_ADVANCE, 32'd0,          48'd1000, 48'd0,    1'b0);
        // An update that does not raise the time still runs the check: wake.
        queue_item(CMD_UPDATE,  32'd0,          48'd0,    48'd0,    1'b0);
        queue_item(CMD_UPDATE,  32'd12345,      48'd9000, 48'd0,    1'b0);
        queue_item(CMD_UPDATE,  32'd0,          48'd3600, TIME_MAX, 1'b0);
        queue_item(CMD_ADVANCE, 32'hFFFF_FFFF,  48'd0,    TIME_MAX, 1'b1);
        n_directed = item_q.size();

        // Random part, weighted towards filling the table early and towards
        // complete wait-then-wake sequences afterwards.
        while (item_q.size() < n_directed + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            lo   = table_floor(PLAN_BANK);
            if (item_q.size() < n_directed + 200 && pick < 35) begin
                // Initialisation traffic: a known source or a fresh one.
                slot = pick_entry(PLAN_BANK);
                tv   = sat_time(lo, t_tstamp'($urandom_range(0, 1 << 20)));
                if (pick < 15 && slot >= 0)
                    queue_item(CMD_UPDATE, tbl_src[PLAN_BANK][slot], tv, rand_time(), 1'b1);
                else
                    queue_item(CMD_UPDATE, $urandom, tv, rand_time(), 1'b1);
            end else if (pick < 60 && live_count(PLAN_BANK) > 0) begin
                // Wait for a target just above the minimum, then raise every
                // entry below it. Some sequences are cut short or have stray
                // items mixed in.
                target = sat_time(lo, t_tstamp'($urandom_range(1, 4000)));
                back   = t_tstamp'($urandom_range(0, 4000));
                if (back > target)
                    back = target;
                queue_item(CMD_WAIT, $urandom, target - back, back, 1'($urandom_range(0, 1)));
                broken = ($urandom_range(0, 4) == 0);
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_valid[PLAN_BANK][i] && tbl_time[PLAN_BANK][i] < target) begin
                        if (broken && $urandom_range(0, 1) == 0)
                            break;
                        if ($urandom_range(0, 5) == 0)
                            queue_item(CMD_UPDATE, $urandom, rand_time(), rand_time(), 1'b0);
                        queue_item(CMD_UPDATE, tbl_src[PLAN_BANK][i],
                                   sat_time(target, t_tstamp'($urandom_range(0, 3000))),
                                   rand_time(), 1'b0);
                    end
                end
            end else if (pick < 72) begin
                // A lone wait: either already satisfied or with a random target.
                if ($urandom_range(0, 1) == 0) begin
                    back = t_tstamp'($urandom_range(0, 4000));
                    if (back > lo)
                        back = lo;
                    queue_item(CMD_WAIT, $urandom, lo - back,
                               t_tstamp'($urandom_range(0, int'(back))), 1'($urandom_range(0, 1)));
                end else begin
                    queue_item(CMD_WAIT, $urandom, rand_time(), rand_time(),
                               1'($urandom_range(0, 1)));
                end
            end else if (pick < 84) begin
                // Run-time update of a known source: lower, far higher or a bit higher.
                slot = pick_entry(PLAN_BANK);
                if (slot >= 0) begin
                    cur  = tbl_time[PLAN_BANK][slot];
                    back = t_tstamp'($urandom_range(0, 3000));
                    if (back > cur)
                        back = cur;
                    case ($urandom_range(0, 3))
                        0:       tv = cur - back;
                        1:       tv = rand_time();
                        default: tv = sat_time(cur, t_tstamp'($urandom_range(0, 3000)));
                    endcase
                    queue_item(CMD_UPDATE, tbl_src[PLAN_BANK][slot], tv, rand_time(), 1'b0);
                end
            end else if (pick < 90) begin
                queue_item(CMD_ADVANCE, $urandom, t_tstamp'($urandom_range(0, 5000)),
                           rand_time(), 1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
                queue_item(CMD_UPDATE, $urandom, rand_time(), rand_time(), 1'b0);
            end else if (pick < 98) begin
                queue_item(CMD_UNUSED, $urandom, rand_time(), rand_time(),
                           1'($urandom_range(0, 1)));
            end else begin
                // Fresh source during initialisation; refused once the table is full.
                tv = sat_time(lo, t_tstamp'($urandom_range(0, 1 << 20)));
                queue_item(CMD_UPDATE, $urandom, tv, rand_time(), 1'b1);
            end
        end

        // Closing items: clip every entry at the top, then a wait whose
        // clipped target is exactly reached, then an update at the top.
        queue_item(CMD_ADVANCE, 32'd0, TIME_MAX, 48'd0, 1'b0);
        queue_item(CMD_WAIT, 32'd0, 48'd1, TIME_MAX, 1'b0);
        queue_item(CMD_UPDATE, 32'd0, 48'd1, 48'd0, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Poll away from the active edge so that the queues are settled.
        @(negedge i_clk);
        while (item_q.size() != 0 || result_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items taken (%0d directed) in %0d cycles, %0d sources at the end",
                 n_accepted, n_directed, n_cycles, live_count(CHECK_BANK));
        $display("status counts: done %0d proceed %0d wait %0d woken %0d unknown %0d full %0d",
                 status_seen[STS_DONE], status_seen[STS_PROCEED], status_seen[STS_WAIT],
                 status_seen[STS_WOKEN], status_seen[STS_UNKNOWN], status_seen[STS_FULL]);
        if (n_errors == 0) begin
            $display("tb_source_time_dependency_tracker: done, clean");
        end else begin
            $display("tb_source_time_dependency_tracker: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/stdt_pkg.sv
hdl/stdt_cell.sv
hdl/source_time_dependency_tracker.sv
verif/tb_source_time_dependency_tracker.sv
